FILE: hdl/address_accept_list_assert.svh
// Assertion macros for the checker file of the address accept list.
`ifndef ADDRESS_ACCEPT_LIST_ASSERT_SVH
`define ADDRESS_ACCEPT_LIST_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define AAL_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define AAL_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hdl/aal_pkg.sv
// Types and constants shared by the address accept list modules.
package aal_pkg;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned EntryW = AddrW + 1;
  localparam int unsigned CountW = 4;

  localparam logic [1:0] RegFilterEnable = 2'd0;

  typedef logic [EntryW-1:0] entry_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [AddrW-1:0] peer_address;
    logic             address_type;
  } in_item_t;

  typedef struct packed {
    logic              allowed;
    logic [1:0]        status;
    logic [CountW-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: hdl/aal_store.sv
// Entry memory of the address accept list with one write and one registered read port.
module aal_store #(
  parameter int unsigned ENTRIES = 8,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk_i,
  input  aal_pkg::mem_ctl_t mem_ctl_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  aal_pkg::entry_t   wr_data_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output aal_pkg::entry_t   rd_data_o
);
  import aal_pkg::*;

  entry_t mem_q [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (mem_ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/aal_seq.sv
// Sequencer that walks the entry memory with one comparator and keeps the result register.
module aal_seq #(
  parameter int unsigned ENTRIES = 8,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               filter_en_i,
  input  logic               in_valid_i,
  input  aal_pkg::in_item_t  in_item_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aal_pkg::out_item_t out_item_o,
  output aal_pkg::mem_ctl_t  mem_ctl_o,
  output logic [IdxW-1:0]    wr_addr_o,
  output aal_pkg::entry_t    wr_data_o,
  output logic [IdxW-1:0]    rd_addr_o,
  input  aal_pkg::entry_t    rd_data_i
);
  import aal_pkg::*;

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(ENTRIES);
  localparam logic [CntW-1:0] OneCnt = CntW'(1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_MOVE_RD = 5'b00100,
    S_MOVE_WR = 5'b01000,
    S_RESP    = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            cmp_v_q, cmp_v_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [1:0]      op_q, op_d;
  entry_t          key_q, key_d;
  logic            allowed_q, allowed_d;
  logic [1:0]      status_q, status_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;
  logic            hit;
  logic [CntW-1:0] last;

  assign hit  = cmp_v_q && (rd_data_i == key_q);
  assign last = count_q - OneCnt;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    slot_d      = slot_q;
    op_d        = op_q;
    key_d       = key_q;
    allowed_d   = allowed_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    mem_ctl_o   = '0;
    wr_addr_o   = slot_q;
    wr_data_o   = key_q;
    rd_addr_o   = scan_q[IdxW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_item_i.opcode;
          key_d     = {in_item_i.address_type, in_item_i.peer_address};
          allowed_d = 1'b0;
          status_d  = ST_DONE;
          scan_d    = '0;
          if (in_item_i.opcode == OP_CLEAR) begin
            count_d = '0;
            state_d = S_RESP;
          end else if ((in_item_i.opcode == OP_CHECK) && !filter_en_i) begin
            allowed_d = 1'b1;
            state_d   = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          unique case (op_q)
            OP_CHECK: begin
              allowed_d = 1'b1;
              state_d   = S_RESP;
            end
            OP_ADD: begin
              status_d = ST_PRESENT;
              state_d  = S_RESP;
            end
            OP_REMOVE: begin
              slot_d  = cmp_idx_q;
              state_d = S_MOVE_RD;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end else if (scan_q < count_q) begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = scan_q[IdxW-1:0];
          cmp_v_d         = 1'b1;
          cmp_idx_d       = scan_q[IdxW-1:0];
          scan_d          = scan_q + OneCnt;
        end else begin
          state_d = S_RESP;
          unique case (op_q)
            OP_CHECK: begin
              allowed_d = 1'b0;
            end
            OP_ADD: begin
              if (count_q >= MaxCnt) begin
                status_d = ST_FULL;
              end else begin
                mem_ctl_o.wr_en = 1'b1;
                wr_addr_o       = count_q[IdxW-1:0];
                wr_data_o       = key_q;
                count_d         = count_q + OneCnt;
              end
            end
            OP_REMOVE: begin
              status_d = ST_NOT_FOUND;
            end
            default: begin
              status_d = ST_DONE;
            end
          endcase
        end
      end
      S_MOVE_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = last[IdxW-1:0];
        state_d         = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = slot_q;
        wr_data_o       = rd_data_i;
        count_d         = last;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_item_d.allowed     = allowed_q;
          out_item_d.status      = status_q;
          out_item_d.entry_count = CountW'(count_q);
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    cmp_idx_q  <= cmp_idx_d;
    slot_q     <= slot_d;
    op_q       <= op_d;
    key_q      <= key_d;
    allowed_q  <= allowed_d;
    status_q   <= status_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hdl/address_accept_list.sv
// Top level of the address accept list with its configuration port.
//
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_item_i (aal_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i  out_item_o (aal_pkg::out_item_t)
// config    input      psel, penable, pwrite      paddr, pwdata, prdata
//
// A clear or a check with filtering off goes straight to the response state, which loads a result
// once no result is held by out_stall_i. A check, add or remove reads one entry per cycle
// through the registered memory port; a remove that compacts the list then moves its last entry
// through a read and a write state. The next item is taken in the cycle after the result is loaded.
// Reset empties the list and clears filter_enable; the entry memory itself is not cleared.
// A result held by out_stall_i delays the next result, not the walk of the next item.
module address_accept_list #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aal_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aal_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import aal_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic            filter_en_q, filter_en_d;
  mem_ctl_t        mem_ctl;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;

  assign pready = 1'b1;

  always_comb begin
    filter_en_d = filter_en_q;
    if (psel && penable && pwrite && (paddr == RegFilterEnable)) begin
      filter_en_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
    end else begin
      filter_en_q <= filter_en_d;
    end
  end

  assign prdata = (paddr == RegFilterEnable) ? {31'd0, filter_en_q} : 32'd0;

  aal_seq #(
    .ENTRIES(ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .filter_en_i(filter_en_q),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .mem_ctl_o  (mem_ctl),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  aal_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk_i    (clk_i),
    .mem_ctl_i(mem_ctl),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule

FILE: hdl/aal_checker.sv
// Port checker for the address accept list and its bind to the top level.
`include "address_accept_list_assert.svh"

module aal_checker #(
  parameter int unsigned ENTRIES = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input aal_pkg::out_item_t out_item_o
);
  import aal_pkg::*;

  localparam bit CountWraps = (ENTRIES > 15);

  `AAL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `AAL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `AAL_ASSERT(a_count_bound, clk_i, rst_ni, !out_valid_o || CountWraps || (out_item_o.entry_count <= CountW'(ENTRIES)))
  `AAL_ASSERT(a_allowed_done, clk_i, rst_ni, !(out_valid_o && out_item_o.allowed) || (out_item_o.status == ST_DONE))

endmodule

bind address_accept_list aal_checker #(
  .ENTRIES(ENTRIES)
) u_aal_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
